// ----- design/hvf_pkg.sv -----
// Shared constants, types and the reciprocal table for the heightmap void fill block.
// No dependencies; every other design file imports this package.
package hvf_pkg;

  // Grid and store sizing
  localparam int MAX_WIDTH   = 2048;
  localparam int STORE_DEPTH = 2 * MAX_WIDTH + 2;
  localparam int SLOT_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(MAX_WIDTH + 1);
  localparam int MIN_WIDTH   = 3;

  // Data widths
  localparam int HGT_W      = 16;
  localparam int SUM_W      = HGT_W + 3;
  localparam int CNT8_W     = 4;
  localparam int RCP_SHIFT  = SUM_W + 3;
  localparam int RCP_W      = RCP_SHIFT + 1;
  localparam int NBR_N      = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int FW_W       = 12;

  typedef logic signed [HGT_W-1:0] hgt_t;
  typedef logic [SLOT_W-1:0]       slot_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  localparam hgt_t LIMIT_RESET = -16'sd32000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH = 1'b0,
    CFG_VOID_LIMIT  = 1'b1
  } cfg_reg_t;

  // 3x3 window: center sample plus eight neighbors, index 0 top-left .. 7 bottom-right
  typedef struct packed {
    hgt_t             center;
    hgt_t [NBR_N-1:0] nbr;
  } win_t;

  // Control from the sequencer to the mean unit
  typedef struct packed {
    logic             load;
    logic [NBR_N-1:0] nbr_ok;
    hgt_t             limit;
  } mean_ctl_t;

  // ceil(2^RCP_SHIFT / n) for n = 1..8, exact for dividends below 2^SUM_W
  localparam logic [RCP_W-1:0] RECIP_TBL [NBR_N] = '{
    RCP_W'((2**RCP_SHIFT + 0) / 1),
    RCP_W'((2**RCP_SHIFT + 1) / 2),
    RCP_W'((2**RCP_SHIFT + 2) / 3),
    RCP_W'((2**RCP_SHIFT + 3) / 4),
    RCP_W'((2**RCP_SHIFT + 4) / 5),
    RCP_W'((2**RCP_SHIFT + 5) / 6),
    RCP_W'((2**RCP_SHIFT + 6) / 7),
    RCP_W'((2**RCP_SHIFT + 7) / 8)
  };

endpackage

// ----- design/heightmap_void_fill.sv -----
// Heightmap void fill, top level: transaction sequencer, grid counters, 3x3 window
// registers and output register. Depends on hvf_pkg, hvf_store and hvf_mean.
//
// Each result comes out one row plus one sample after its sample; after the last
// sample of a frame, frame_width + 1 flush transactions drain the rest, and the
// last one carries frame_end. Each transaction sums the valid neighbors in the sum state
// and divides through the reciprocal table in the divide state; the next one is taken
// only as that divide finishes, since its sum needs the filled value that this divide
// produces for its left neighbor. A flush before the frame is complete enters neither
// state and gives no result. A stalled out_ready holds the divide state until the
// output register frees. The line store (4098 x 16) is not cleared after reset; no
// entry not yet written in the current frame reaches a result. Write the
// configuration only while the block is idle; a frame_width write restarts the frame.
module heightmap_void_fill
  import hvf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [HGT_W-1:0] in_sample_in,
  input  logic                    in_flush,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [HGT_W-1:0] out_filled_height,
  output logic                    out_frame_end,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SUM  = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  state_t    state_r, state_nxt;

  // Configuration
  cnt_t      width_r;
  hgt_t      limit_r;
  logic      cfg_wr;
  logic      cfg_restart;
  logic [FW_W-1:0] fw_raw;
  cnt_t      width_clamp;

  // Grid counters and ring pointer
  cnt_t      in_row_r, in_row_nxt;
  cnt_t      in_col_r, in_col_nxt;
  cnt_t      out_row_r, out_row_nxt;
  cnt_t      out_col_r, out_col_nxt;
  slot_t     wp_r, wp_nxt;

  cnt_t      w_m1;
  slot_t     w_s;
  slot_t     two_w;
  slot_t     ring_size;
  slot_t     wp_inc;
  slot_t     rd_mid_addr;
  slot_t     rd_top_addr;
  slot_t     res_slot;

  // Transaction decode
  logic      in_done;
  logic      is_drop;
  logic      is_samp;
  logic      is_drain;
  logic      emit_now;
  logic      out_last;
  logic      accept;
  logic      take;
  logic      fin;

  // Per-transaction registers
  logic      emit_r;
  logic      smp_r;
  logic      last_r;
  cnt_t      p_row_r;
  cnt_t      p_col_r;
  hgt_t      smp_data_r;
  slot_t     smp_slot_r;
  slot_t     res_slot_r;

  // Window registers
  hgt_t      top_a_r;
  hgt_t      top_b_r;
  hgt_t      mid_c_r;
  hgt_t      bot_a_r;
  hgt_t      bot_b_r;
  hgt_t      left_r;
  hgt_t      rd_top_data;
  hgt_t      rd_mid_data;

  // Output register
  logic      out_valid_r;
  hgt_t      out_hgt_r;
  logic      out_end_r;

  // Store and mean unit hookup
  logic      st_we;
  slot_t     st_waddr;
  hgt_t      st_wdata;
  mean_ctl_t mean_ctl;
  win_t      win;
  hgt_t      result;
  logic      row_top, row_bot, col_lft, col_rgt;

  // Configuration write path, always ready
  assign cfg_ready   = 1'b1;
  assign cfg_wr      = cfg_valid && cfg_ready;
  assign cfg_restart = cfg_wr && (cfg_reg_t'(cfg_index) == CFG_FRAME_WIDTH);
  assign fw_raw      = cfg_data[FW_W-1:0];

  // Clamp the written width into the supported range
  always_comb begin
    if (fw_raw < FW_W'(MIN_WIDTH)) begin
      width_clamp = cnt_t'(MIN_WIDTH);
    end else if (fw_raw > MAX_WIDTH) begin
      width_clamp = cnt_t'(MAX_WIDTH);
    end else begin
      width_clamp = cnt_t'(fw_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= cnt_t'(MAX_WIDTH);
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FRAME_WIDTH: width_r <= width_clamp;
        CFG_VOID_LIMIT:  limit_r <= hgt_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // Ring geometry: 2w + 2 slots, position q lives at slot q mod ring_size
  assign w_m1      = width_r - cnt_t'(1);
  assign w_s       = slot_t'(width_r);
  assign two_w     = w_s + w_s;
  assign ring_size = two_w + slot_t'(2);
  assign wp_inc    = (wp_r + slot_t'(1) == ring_size) ? '0 : wp_r + slot_t'(1);

  // Slots one row back, two rows back and one row plus one back, with wrap
  assign rd_mid_addr = (wp_r >= w_s)   ? wp_r - w_s   : wp_r + w_s + slot_t'(2);
  assign rd_top_addr = (wp_r >= two_w) ? wp_r - two_w : wp_r + slot_t'(2);
  assign res_slot    = (wp_r > w_s)    ? wp_r - w_s - slot_t'(1) : wp_r + w_s + slot_t'(1);

  // Classify the incoming transaction
  assign in_done  = in_row_r >= width_r;
  assign is_drop  = !in_done && in_flush;
  assign is_samp  = !in_done && !in_flush;
  assign is_drain = in_done;
  assign emit_now = is_drain ||
                    (is_samp && ((in_row_r > cnt_t'(1)) ||
                                 ((in_row_r == cnt_t'(1)) && (in_col_r != '0))));
  assign out_last = (out_row_r == w_m1) && (out_col_r == w_m1);

  // Handshakes
  assign fin      = (state_r == S_DIV) && (!emit_r || !out_valid_r || out_ready);
  assign in_ready = (state_r == S_IDLE) || fin;
  assign accept   = in_valid && in_ready;
  assign take     = accept && !is_drop;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) state_nxt = S_SUM;
      end
      S_SUM: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (fin) state_nxt = take ? S_SUM : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance grid counters and ring pointer at each taken transaction
  always_comb begin
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    wp_nxt      = wp_r;
    if (take) begin
      wp_nxt = wp_inc;
      if (is_samp) begin
        if (in_col_r == w_m1) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + cnt_t'(1);
        end else begin
          in_col_nxt = in_col_r + cnt_t'(1);
        end
      end
      if (emit_now) begin
        if (out_col_r == w_m1) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + cnt_t'(1);
        end else begin
          out_col_nxt = out_col_r + cnt_t'(1);
        end
      end
      // Last result of the frame: start over
      if (is_drain && out_last) begin
        in_row_nxt  = '0;
        in_col_nxt  = '0;
        out_row_nxt = '0;
        out_col_nxt = '0;
        wp_nxt      = '0;
      end
    end
    if (cfg_restart) begin
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      out_row_nxt = '0;
      out_col_nxt = '0;
      wp_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      wp_r      <= '0;
      emit_r    <= 1'b0;
      smp_r     <= 1'b0;
    end else begin
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
      wp_r      <= wp_nxt;
      if (take) begin
        emit_r <= emit_now;
        smp_r  <= is_samp;
      end
    end
  end

  // Capture transaction payload and positions
  always_ff @(posedge clk) begin
    if (take) begin
      smp_data_r <= in_sample_in;
      smp_slot_r <= wp_r;
      res_slot_r <= res_slot;
      if (emit_now) begin
        p_row_r <= out_row_r;
        p_col_r <= out_col_r;
        last_r  <= out_last;
      end
    end
  end

  // Shift the window one column when the divide completes
  always_ff @(posedge clk) begin
    if (fin) begin
      top_a_r <= top_b_r;
      top_b_r <= rd_top_data;
      mid_c_r <= rd_mid_data;
      bot_a_r <= bot_b_r;
      bot_b_r <= smp_data_r;
      left_r  <= result;
    end
  end

  // Store writes: raw sample in the sum cycle, filled result in the divide cycle
  always_comb begin
    st_we    = 1'b0;
    st_waddr = smp_slot_r;
    st_wdata = smp_data_r;
    if ((state_r == S_SUM) && smp_r) begin
      st_we = 1'b1;
    end else if (fin && emit_r) begin
      st_we    = 1'b1;
      st_waddr = res_slot_r;
      st_wdata = result;
    end
  end

  hvf_store u_store (
    .clk       (clk),
    .wr_en     (st_we),
    .wr_addr   (st_waddr),
    .wr_data   (st_wdata),
    .rd_en     (take),
    .rd_addr_a (rd_top_addr),
    .rd_addr_b (rd_mid_addr),
    .rd_data_a (rd_top_data),
    .rd_data_b (rd_mid_data)
  );

  // Mask neighbors that fall outside the grid
  assign row_top = p_row_r != '0;
  assign row_bot = p_row_r != w_m1;
  assign col_lft = p_col_r != '0;
  assign col_rgt = p_col_r != w_m1;

  always_comb begin
    mean_ctl.load   = state_r == S_SUM;
    mean_ctl.limit  = limit_r;
    mean_ctl.nbr_ok = {row_bot & col_rgt, row_bot, row_bot & col_lft, col_rgt,
                       col_lft, row_top & col_rgt, row_top, row_top & col_lft};
    win.center      = mid_c_r;
    win.nbr         = {smp_data_r, bot_b_r, bot_a_r, rd_mid_data,
                       left_r, rd_top_data, top_b_r, top_a_r};
  end

  hvf_mean u_mean (
    .clk    (clk),
    .ctl    (mean_ctl),
    .win    (win),
    .result (result)
  );

  // Output register: load on a finished result, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin && emit_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin && emit_r) begin
      out_hgt_r <= result;
      out_end_r <= last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_filled_height = out_hgt_r;
  assign out_frame_end     = out_end_r;

  // Checks
  a_wp_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r < ring_size)
    else $error("ring pointer outside the ring");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (take && is_drain && out_last) |=>
      (in_row_r == '0 && in_col_r == '0 && out_row_r == '0 && wp_r == '0))
    else $error("counters not cleared after last result of frame");

  a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DIV && emit_r))
    else $error("result loaded outside a divide cycle");

  a_no_take_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM) |-> (!in_ready && !st_we || smp_r))
    else $error("transaction accepted during a sum cycle");

endmodule

// ----- design/hvf_store.sv -----
// Line store: ring of two rows plus two samples, one write port and two read ports.
// Read data is registered. Depends on hvf_pkg.
module hvf_store
  import hvf_pkg::*;
(
  input  logic  clk,
  input  logic  wr_en,
  input  slot_t wr_addr,
  input  hgt_t  wr_data,
  input  logic  rd_en,
  input  slot_t rd_addr_a,
  input  slot_t rd_addr_b,
  output hgt_t  rd_data_a,
  output hgt_t  rd_data_b
);

  hgt_t mem [STORE_DEPTH];
  hgt_t rd_a_r;
  hgt_t rd_b_r;

  // Write one entry per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read two entries, hold data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// ----- design/hvf_mean.sv -----
// Neighbor mean unit: registered sum and count of valid neighbors, then a
// reciprocal multiply that divides with truncation toward zero. Depends on hvf_pkg.
module hvf_mean
  import hvf_pkg::*;
(
  input  logic      clk,
  input  mean_ctl_t ctl,
  input  win_t      win,
  output hgt_t      result
);

  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [SUM_W-1:0]  sum_r;
  logic [CNT8_W-1:0]        cnt_nxt;
  logic [CNT8_W-1:0]        cnt_r;
  logic                     void_r;
  hgt_t                     center_r;
  logic [SUM_W-1:0]         mag;
  logic [RCP_W-1:0]         rcp;
  logic [$clog2(NBR_N)-1:0] rcp_idx;
  logic [RCP_W+SUM_W-1:0]   prod;
  logic [HGT_W:0]           quo;
  hgt_t                     mean_v;

  // Add up neighbors that lie inside the grid and sit above the limit
  always_comb begin
    sum_nxt = '0;
    cnt_nxt = '0;
    for (int k = 0; k < NBR_N; k++) begin
      if (ctl.nbr_ok[k] && ($signed(win.nbr[k]) > $signed(ctl.limit))) begin
        sum_nxt = sum_nxt + SUM_W'($signed(win.nbr[k]));
        cnt_nxt = cnt_nxt + CNT8_W'(1);
      end
    end
  end

  // Hold sum, count and center for the divide cycle
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sum_r    <= sum_nxt;
      cnt_r    <= cnt_nxt;
      center_r <= win.center;
      void_r   <= $signed(win.center) < $signed(ctl.limit);
    end
  end

  // Divide magnitude by count through the reciprocal table; zero count gives zero
  always_comb begin
    mag     = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    rcp_idx = $clog2(NBR_N)'(cnt_r - CNT8_W'(1));
    rcp     = (cnt_r == '0) ? '0 : RECIP_TBL[rcp_idx];
    prod    = mag * rcp;
    quo     = prod[RCP_SHIFT +: HGT_W+1];
    mean_v  = sum_r[SUM_W-1] ? hgt_t'(-quo) : hgt_t'(quo);
    result  = void_r ? mean_v : center_r;
  end

endmodule

// ----- test/tb_heightmap_void_fill.sv -----
// Testbench for heightmap_void_fill: directed and random frames checked against a
// void-fill predictor held in a small scoreboard class. Depends on hvf_pkg and the RTL.
module tb_heightmap_void_fill;
  import hvf_pkg::*;

  localparam int RANDOM_ITEMS  = 1750;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 400;
  // about 4000 transactions and their idle waits, taken many times over
  localparam int CYCLE_LIMIT   = 600000;
  localparam int MAX_PRINTS    = 50;

  typedef struct {
    hgt_t height;
    logic frame_end;
  } fill_result_t;

  // Void-fill predictor and queue of expected filled heights
  class void_fill_scoreboard;
    logic [FW_W-1:0] width_reg;
    hgt_t            limit;
    int              in_row, in_col, out_row, out_col;
    int              heights[int];
    fill_result_t    pending_fills[$];
    int              errors;

    function new();
      width_reg = FW_W'(MAX_WIDTH);
      limit     = LIMIT_RESET;
      errors    = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      in_row  = 0;
      in_col  = 0;
      out_row = 0;
      out_col = 0;
      heights.delete();
    endfunction

    function int eff_width();
      int w;
      w = width_reg;
      if (w < MIN_WIDTH) w = MIN_WIDTH;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
    endfunction

    function int pending();
      return pending_fills.size();
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FRAME_WIDTH: begin
          width_reg = data[FW_W-1:0];
          restart_frame();
        end
        CFG_VOID_LIMIT: limit = hgt_t'(data);
      endcase
    endfunction

    // Fill the grid position at the output counters; neighbors above and left are
    // already filled in the store, the rest are still raw
    function void predict_fill(int w);
      int           pos, sum, count, r, c, v, di, dj;
      hgt_t         res;
      fill_result_t e;
      pos = out_row * w + out_col;
      res = hgt_t'(heights[pos]);
      if (res < limit) begin
        sum   = 0;
        count = 0;
        for (di = -1; di <= 1; di++) begin
          for (dj = -1; dj <= 1; dj++) begin
            r = out_row + di;
            c = out_col + dj;
            if ((di != 0 || dj != 0) && r >= 0 && c >= 0 && r < w && c < w) begin
              v = heights[r * w + c];
              if (v > limit) begin
                sum += v;
                count++;
              end
            end
          end
        end
        res = (count > 0) ? hgt_t'(sum / count) : hgt_t'(0);
      end
      heights[pos] = res;
      e.height     = res;
      e.frame_end  = (out_row == w - 1 && out_col == w - 1);
      pending_fills.push_back(e);
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    endfunction

    // Note one accepted input transaction
    function void note_input(hgt_t sample, logic flush);
      int w;
      w = eff_width();
      if (in_row < w && !flush) begin
        heights[in_row * w + in_col] = sample;
        if (in_row * w + in_col >= w + 1) predict_fill(w);
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
        end
      end else if (in_row >= w) begin
        // drain one result; a sample here counts as a flush
        predict_fill(w);
        if (out_row >= w) restart_frame();
      end
    endfunction

    task report(string what);
      if (errors < MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    // Check one accepted output transaction against the oldest expectation
    task check_result(hgt_t got_height, logic got_end);
      fill_result_t e;
      if (pending_fills.size() == 0) begin
        report($sformatf("unexpected result height %0d", got_height));
        return;
      end
      e = pending_fills.pop_front();
      if (got_height !== e.height)
        report($sformatf("filled_height %0d, want %0d", got_height, e.height));
      if (got_end !== e.frame_end)
        report($sformatf("frame_end %b, want %b", got_end, e.frame_end));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  hgt_t                  in_sample_in = '0;
  logic                  in_flush = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  hgt_t                  out_filled_height;
  logic                  out_frame_end;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  void_fill_scoreboard sb = new();

  int cycle_count = 0;
  int items_sent  = 0;
  int burst_left  = 0;
  int hold_asked  = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int rx_mode     = 0;
  int mode_left   = 0;

  heightmap_void_fill uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_in     (in_sample_in),
    .in_flush         (in_flush),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_filled_height(out_filled_height),
    .out_frame_end    (out_frame_end),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Stop a hung run
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Observe both channels at each edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_sample_in, in_flush);
      if (out_valid && out_ready) sb.check_result(out_filled_height, out_frame_end);
    end
  end

  // Receiver: hold off for a long stretch on request, else stall on a changing pattern
  always @(posedge clk) begin
    if (hold_asked != hold_seen) begin
      hold_seen <= hold_asked;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ((cycle_count % 7) < 3);
      endcase
    end
  end

  // Sample mix around the current limit: equal, void, near, extreme and anything
  function automatic hgt_t pick_sample(hgt_t lim);
    int v;
    case ($urandom_range(0, 9))
      0: v = lim;
      1, 2, 3: v = (lim > -32768) ? int'($urandom_range(0, lim + 32767)) - 32768 : lim;
      4: v = lim + int'($urandom_range(0, 6)) - 3;
      5: v = $urandom_range(0, 1) ? 32767 : -32768;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return hgt_t'(v);
  endfunction

  function automatic hgt_t pick_limit();
    case ($urandom_range(0, 9))
      0: return hgt_t'(-32768);
      1: return hgt_t'(32767);
      2: return LIMIT_RESET;
      3, 4, 5: return hgt_t'(int'($urandom_range(0, 2000)) - 1000);
      default: return hgt_t'($urandom);
    endcase
  endfunction

  // Mostly small widths, a few below the minimum, a few wider; junk in the upper bits
  function automatic logic [CFG_DATA_W-1:0] pick_width();
    int                    k, w;
    logic [CFG_DATA_W-1:0] d;
    k = $urandom_range(0, 19);
    if (k == 0) w = $urandom_range(0, 2);
    else if (k == 1) w = $urandom_range(10, 16);
    else w = $urandom_range(3, 9);
    d = $urandom;
    d[FW_W-1:0] = FW_W'(w);
    return d;
  endfunction

  // Drop valid and hold until every expected result has come
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // Write one register once the block is idle
  task automatic set_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // Offer one transaction; keep valid high inside a burst, drop it for a gap after
  task automatic send_item(input hgt_t sample, input logic flush);
    int gap;
    in_valid     <= 1'b1;
    in_sample_in <= sample;
    in_flush     <= flush;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // One 3x3 frame at the reset limit: edges, voids, a sample equal to the limit,
  // extremes, early flushes and a sample used as a flush
  task automatic run_directed();
    int vals [9] = '{-7, -32768, -32000, -32001, -4, 32767, -32768, 32767, -32768};
    set_register(CFG_FRAME_WIDTH, '0);
    send_item(hgt_t'(16'h1234), 1'b1);
    foreach (vals[k]) send_item(hgt_t'(vals[k]), 1'b0);
    send_item(hgt_t'(16'h5a5a), 1'b1);
    send_item(hgt_t'(32767), 1'b0);
    send_item(hgt_t'(-32768), 1'b1);
    send_item(hgt_t'(0), 1'b1);
    send_item(hgt_t'(16'hffff), 1'b1);
  endtask

  // Width above the maximum: push just past one row so a couple of results appear
  task automatic run_wide_partial();
    int n, w;
    set_register(CFG_FRAME_WIDTH, 16'h0fff);
    w = sb.eff_width();
    for (n = 0; n < w + 3; n++) send_item(pick_sample(sb.limit), 1'b0);
  endtask

  // Send one frame with early-flush noise and drain it, or stop partway through
  task automatic run_frame(input int w, input bit cut_short);
    int total, cut, n;
    total = w * w;
    cut   = cut_short ? $urandom_range(1, total - 1) : total;
    n     = 0;
    while (n < cut) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(pick_sample(sb.limit), 1'b1);
      end else begin
        send_item(pick_sample(sb.limit), 1'b0);
        n++;
      end
      if ($urandom_range(0, 49) == 0) wait_drained();
    end
    if (!cut_short) begin
      for (n = 0; n <= w; n++) send_item(pick_sample(sb.limit), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_random();
    int phase, target, frames, f, w;
    bit restart, cut_short;
    phase   = 0;
    restart = 1'b1;
    target  = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(0, 2) == 0) set_register(CFG_VOID_LIMIT, pick_limit());
      if (restart || $urandom_range(0, 2) == 0) set_register(CFG_FRAME_WIDTH, pick_width());
      restart = 1'b0;
      w = sb.eff_width();
      // long receiver hold-off while frames keep coming
      if (phase == 3) hold_asked <= hold_asked + 1;
      frames = $urandom_range(1, 3);
      for (f = 0; f < frames && !restart; f++) begin
        cut_short = ($urandom_range(0, 9) == 0);
        run_frame(w, cut_short);
        restart = cut_short;
      end
      phase++;
    end
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_wide_partial();
    set_register(CFG_VOID_LIMIT, 16'h8000);
    set_register(CFG_FRAME_WIDTH, 16'd3);
    run_frame(3, 1'b0);
    set_register(CFG_VOID_LIMIT, 16'h7fff);
    run_frame(3, 1'b0);
    run_random();
    wait_drained();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never came", sb.pending()));
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
